// File: rtl/core/ile_pkg.sv
package ile_pkg;

    localparam int CAPACITY = 64;

    // Position and count width: holds CAPACITY itself and every 7-bit index.
    localparam int POS_W = ($clog2(CAPACITY + 1) > 7) ? $clog2(CAPACITY + 1) : 7;

    // Read taps are folded in groups of eight cells, then across the groups.
    localparam int GRP_SIZE = 8;
    localparam int GROUPS = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic [2:0] KIND_READ = 3'd0;
    localparam logic [2:0] KIND_HEAD = 3'd1;
    localparam logic [2:0] KIND_TAIL = 3'd2;
    localparam logic [2:0] KIND_AT   = 3'd3;
    localparam logic [2:0] KIND_DEL  = 3'd4;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [6:0]         index;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               read_ok;
        logic [1:0]         status;
        logic [6:0]         length;
    } out_word_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic               write_en;
        logic               del;
        logic [POS_W-1:0]   pos;
        logic signed [31:0] value;
    } cell_ctrl_t;

endpackage

// File: rtl/core/ile_cell.sv
module ile_cell (
    input  logic                      aclk,
    input  logic [ile_pkg::POS_W-1:0] cell_idx,
    input  ile_pkg::cell_ctrl_t       ctrl,
    input  logic signed [31:0]        left_val,
    input  logic signed [31:0]        right_val,
    output logic signed [31:0]        cur_val,
    output logic signed [31:0]        tap
);
    import ile_pkg::*;

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    // An insert moves every entry from the position on one cell up and writes the
    // new value at the position, a delete pulls every entry above it one cell down.
    always_comb begin
        value_next = value_reg;
        if (ctrl.write_en) begin
            if (ctrl.del) begin
                if (cell_idx >= ctrl.pos) begin
                    value_next = right_val;
                end
            end else if (cell_idx > ctrl.pos) begin
                value_next = left_val;
            end else if (cell_idx == ctrl.pos) begin
                value_next = ctrl.value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign cur_val = value_reg;
    assign tap     = (cell_idx == ctrl.pos) ? value_reg : '0;

endmodule

// File: rtl/core/indexed_list_engine_top.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// one entry per cell. Commands read, insert at head, tail or before an index,
// and delete at an index; every accepted word returns exactly one result word.
// An item passes through the accept state, the shift state in which the whole
// cell row shifts in parallel (and the read taps are folded per group of eight
// cells), and the finish state that folds the groups into the result register.
// A new word is accepted only after the result of the last one is loaded; a
// waiting result does not block the next accept, only the next result load.
// Entries have no reset; only entries below the count are ever read.
module indexed_list_engine_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ile_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ile_pkg::out_word_t m_data
);
    import ile_pkg::*;

    state_t state_reg, state_next;
    logic [POS_W-1:0] count_reg, count_next;
    logic [2:0]       kind_reg, kind_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic signed [31:0] value_reg, value_next;
    logic [1:0]       status_reg, status_next;
    logic             apply_reg, apply_next;
    logic             del_reg, del_next;
    logic             read_ok_reg, read_ok_next;
    logic             m_valid_reg, m_valid_next;
    out_word_t        out_reg, out_next;

    logic signed [31:0] group_reg [GROUPS];
    logic signed [31:0] group_next [GROUPS];
    logic signed [31:0] cell_val [CAPACITY];
    logic signed [31:0] cell_tap [CAPACITY];
    logic signed [31:0] folded;

    cell_ctrl_t ctrl;
    logic [POS_W-1:0] index_ext;
    logic             full;
    logic             accept;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign index_ext = POS_W'(s_data.index);
    assign full      = (count_reg >= POS_W'(CAPACITY));

    assign ctrl.write_en = (state_reg == ST_EXEC) && apply_reg;
    assign ctrl.del      = del_reg;
    assign ctrl.pos      = pos_reg;
    assign ctrl.value    = value_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [31:0] left_val;
            logic signed [31:0] right_val;
            if (gi == 0) begin : g_first
                assign left_val = '0;
            end else begin : g_left
                assign left_val = cell_val[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_val = '0;
            end else begin : g_right
                assign right_val = cell_val[gi+1];
            end
            ile_cell u_cell (
                .aclk      (aclk),
                .cell_idx  (POS_W'(gi)),
                .ctrl      (ctrl),
                .left_val  (left_val),
                .right_val (right_val),
                .cur_val   (cell_val[gi]),
                .tap       (cell_tap[gi])
            );
        end
    endgenerate

    // First fold level: each group ORs the taps of its cells; only the cell
    // at the read position drives a nonzero tap.
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            group_next[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++) begin
                if (g * GRP_SIZE + j < CAPACITY) begin
                    group_next[g] = group_next[g] | cell_tap[g * GRP_SIZE + j];
                end
            end
        end
    end

    always_comb begin
        folded = '0;
        for (int g = 0; g < GROUPS; g++) begin
            folded = folded | group_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC) begin
            for (int g = 0; g < GROUPS; g++) begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        kind_next    = kind_reg;
        pos_next     = pos_reg;
        value_next   = value_reg;
        status_next  = status_reg;
        apply_next   = apply_reg;
        del_next     = del_reg;
        read_ok_next = read_ok_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next    = s_data.kind;
                    value_next   = s_data.value;
                    pos_next     = index_ext;
                    status_next  = STATUS_DONE;
                    apply_next   = 1'b0;
                    del_next     = 1'b0;
                    read_ok_next = 1'b0;
                    case (s_data.kind)
                        KIND_READ: begin
                            if (index_ext < count_reg) begin
                                read_ok_next = 1'b1;
                            end else begin
                                status_next = STATUS_RANGE;
                            end
                        end
                        KIND_HEAD: begin
                            pos_next = '0;
                            if (full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                apply_next = 1'b1;
                            end
                        end
                        KIND_TAIL: begin
                            pos_next = count_reg;
                            if (full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                apply_next = 1'b1;
                            end
                        end
                        KIND_AT: begin
                            if (index_ext > count_reg) begin
                                status_next = STATUS_RANGE;
                            end else if (full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                apply_next = 1'b1;
                            end
                        end
                        KIND_DEL: begin
                            del_next = 1'b1;
                            if (index_ext >= count_reg) begin
                                status_next = STATUS_RANGE;
                            end else begin
                                apply_next = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (apply_reg) begin
                    count_next = del_reg ? count_reg - 1'b1 : count_reg + 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.read_ok = read_ok_reg;
                    out_next.status  = status_reg;
                    out_next.length  = count_reg[6:0];
                    if (read_ok_reg) begin
                        out_next.read_value = folded;
                    end else if (kind_reg == KIND_READ) begin
                        out_next.read_value = -32'sd1;
                    end else begin
                        out_next.read_value = '0;
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        pos_reg     <= pos_next;
        value_reg   <= value_next;
        status_reg  <= status_next;
        apply_reg   <= apply_next;
        del_reg     <= del_next;
        read_ok_reg <= read_ok_next;
        out_reg     <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= POS_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted word did not start the shift cycle");

    a_exec_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXEC |=> state_reg == ST_FINISH)
        else $error("shift cycle not followed by result fold");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_EXEC |=> $stable(count_reg))
        else $error("entry count changed outside the shift cycle");

endmodule

// File: verif/tb_top.sv
module tb_top;
    import ile_pkg::*;

    // Kinds above delete are undefined commands; the block must leave the list alone.
    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

    localparam int RANDOM_WORDS = 1150;
    localparam int QUIET_WORDS  = 150;

    class list_scoreboard;
        logic signed [31:0] model_list[$];
        out_word_t          pending_results[$];
        int unsigned        mismatches = 0;

        function int unsigned entry_count();
            return model_list.size();
        endfunction

        // Applies one accepted word to the list model and queues its result.
        function void note_input(in_word_t w);
            out_word_t   r;
            int unsigned cnt;
            bit          full;
            r    = '0;
            cnt  = model_list.size();
            full = (cnt >= CAPACITY);
            case (w.kind)
                KIND_READ: begin
                    if (w.index < cnt) begin
                        r.read_value = model_list[w.index];
                        r.read_ok    = 1'b1;
                    end else begin
                        r.read_value = -32'sd1;
                        r.status     = STATUS_RANGE;
                    end
                end
                KIND_HEAD: begin
                    if (full) r.status = STATUS_FULL;
                    else model_list.push_front(w.value);
                end
                KIND_TAIL: begin
                    if (full) r.status = STATUS_FULL;
                    else model_list.push_back(w.value);
                end
                KIND_AT: begin
                    // The range check wins over the full check.
                    if (w.index > cnt) r.status = STATUS_RANGE;
                    else if (full) r.status = STATUS_FULL;
                    else model_list.insert(int'(w.index), w.value);
                end
                KIND_DEL: begin
                    if (w.index >= cnt) r.status = STATUS_RANGE;
                    else model_list.delete(int'(w.index));
                end
                default: ;
            endcase
            r.length = 7'(model_list.size());
            pending_results.push_back(r);
        endfunction

        function void check_result(out_word_t got);
            out_word_t exp;
            if (pending_results.size() == 0) begin
                $error("result word arrived with nothing expected");
                mismatches++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.read_value !== exp.read_value) begin
                $error("read_value: expected %0d, got %0d", exp.read_value, got.read_value);
                mismatches++;
            end
            if (got.read_ok !== exp.read_ok) begin
                $error("read_ok: expected %0d, got %0d", exp.read_ok, got.read_ok);
                mismatches++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                mismatches++;
            end
            if (got.length !== exp.length) begin
                $error("length: expected %0d, got %0d", exp.length, got.length);
                mismatches++;
            end
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    list_scoreboard sb = new();
    bit             quiet = 1'b0;
    int unsigned    send_gap_pct = 25;
    int unsigned    stall_pct = 0;
    int unsigned    stall_left = 0;
    int unsigned    ready_cycles = 0;

    indexed_list_engine_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // Result side back-pressure: random stall bursts, rate changing over time.
    always @(negedge aclk) begin
        if (ready_cycles % 200 == 0) begin
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 10;
                default: stall_pct = 30;
            endcase
        end
        ready_cycles++;
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 11) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_word(in_word_t w);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
            gap = $urandom_range(1, 11);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(w);
    endtask

    task automatic issue(logic [2:0] kind, int unsigned index, logic signed [31:0] value);
        in_word_t w;
        w.kind  = kind;
        w.index = 7'(index);
        w.value = value;
        send_word(w);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Growing mode favors inserts so the list fills up; shrinking mode favors deletes.
    function automatic in_word_t next_command(bit growing);
        in_word_t    w;
        int unsigned cnt;
        int unsigned roll;
        int unsigned sel;
        cnt  = sb.entry_count();
        roll = $urandom_range(0, 99);
        if (growing) begin
            if (roll < 20) w.kind = KIND_HEAD;
            else if (roll < 40) w.kind = KIND_TAIL;
            else if (roll < 65) w.kind = KIND_AT;
            else if (roll < 85) w.kind = KIND_READ;
            else if (roll < 95) w.kind = KIND_DEL;
            else w.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        end else begin
            if (roll < 55) w.kind = KIND_DEL;
            else if (roll < 75) w.kind = KIND_READ;
            else if (roll < 82) w.kind = KIND_HEAD;
            else if (roll < 88) w.kind = KIND_TAIL;
            else if (roll < 95) w.kind = KIND_AT;
            else w.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        end
        sel = $urandom_range(0, 9);
        if (sel == 0) w.index = 7'($urandom_range(0, 127));
        else if (sel == 1) w.index = 7'(cnt);
        else if (w.kind == KIND_AT) w.index = 7'($urandom_range(0, cnt));
        else w.index = (cnt == 0) ? 7'd0 : 7'($urandom_range(0, cnt - 1));
        w.value = pick_value();
        return w;
    endfunction

    initial begin
        bit growing;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty list: indexed reads, deletes and inserts past the count are out of range.
        issue(KIND_READ, 0, 32'sd0);
        issue(KIND_DEL, 0, 32'sd0);
        issue(KIND_AT, 1, 32'sd9);
        issue(KIND_AT, 0, 32'sd5);
        issue(KIND_HEAD, 0, 32'sh8000_0000);
        issue(KIND_TAIL, 127, 32'sh7FFF_FFFF);
        issue(KIND_TAIL, 0, 32'sd0);
        issue(KIND_HEAD, 127, -32'sd1);
        // Insert before an index equal to the count appends at the tail.
        issue(KIND_AT, 5, 32'sh1234_5678);
        issue(KIND_AT, 2, 32'sh5A5A_5A5A);
        issue(KIND_READ, 0, 32'sd0);
        issue(KIND_READ, 6, 32'sd0);
        issue(KIND_READ, 7, 32'sd0);
        issue(KIND_READ, 127, 32'sd0);
        issue(KIND_DEL, 127, 32'sd0);
        issue(KIND_AT, 127, 32'sd1);
        issue(KIND_AT, 8, 32'sd1);
        issue(KIND_DEL, 0, 32'sd0);
        issue(KIND_DEL, 5, 32'sd0);
        issue(KIND_UNUSED_LO, 127, -32'sd1);
        issue(3'd6, 0, 32'sh7FFF_FFFF);
        issue(KIND_UNUSED_HI, 64, 32'sh8000_0000);
        issue(KIND_READ, 2, 32'sd0);
        drain_results();

        growing = 1'b1;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: send_gap_pct = 0;
                    1: send_gap_pct = 25;
                    default: send_gap_pct = 50;
                endcase
            end
            if (i == RANDOM_WORDS / 2) drain_results();
            if (i == RANDOM_WORDS - QUIET_WORDS) quiet = 1'b1;
            // Linger at the extremes for a while so the full and empty cases repeat.
            if (sb.entry_count() == CAPACITY && $urandom_range(0, 15) == 0) growing = 1'b0;
            else if (sb.entry_count() == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
            else if ($urandom_range(0, 199) == 0) growing = !growing;
            send_word(next_command(growing));
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
